// File: design/nsl_pkg.sv
// ---------------------------------------------------------------------------
// nsl_pkg: shared types and constants of the nine-slice layout unit
// Field widths, register indexes, geometry and request structs, slice
// row and column lookup.
// ---------------------------------------------------------------------------
package nsl_pkg;

  localparam int SLICES     = 9;
  localparam int IDX_W      = 4;
  localparam int COORD_W    = 11;
  localparam int BORDER_W   = 8;
  localparam int DIM_W      = 16;
  localparam int POS_W      = 16;
  localparam int DST_W      = 18;
  localparam int SCALE_W    = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = 5;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int Q_CNT_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRITE_W,
    REG_SPRITE_H,
    REG_BORDER_L,
    REG_BORDER_R,
    REG_BORDER_T,
    REG_BORDER_B,
    REG_TARGET_W,
    REG_TARGET_H
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CALC_LOAD,
    CALC_RUN,
    CALC_IDLE
  } calc_state_t;

  // One axis of the grid: three spans, in order low border, middle, high border
  typedef struct packed {
    logic [2:0][COORD_W-1:0] src_pos;
    logic [2:0][COORD_W-1:0] src_len;
    logic [2:0][DIM_W-1:0]   dst_len;
    logic [2:0][DIM_W-1:0]   dst_off;
    logic [2:0]              ok;
  } axis_t;

  typedef struct packed {
    axis_t                   col;
    axis_t                   row;
    logic [2:0][SCALE_W-1:0] scale_x;
    logic [2:0][SCALE_W-1:0] scale_y;
    logic                    present;
  } geom_t;

  // One queued request: slices still to emit and per-span destination origins
  typedef struct packed {
    logic [SLICES-1:0]     mask;
    logic [2:0][DST_W-1:0] dst_x;
    logic [2:0][DST_W-1:0] dst_y;
  } slice_req_t;

  function automatic logic [1:0] slice_row(input logic [IDX_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slice_col(input logic [IDX_W-1:0] k);
    logic [1:0] c;
    unique case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/nsl_div.sv
// ---------------------------------------------------------------------------
// nsl_div: bit-serial restoring divider
// Computes (numer << 16) / denom, one quotient bit per step, 32 steps.
// ---------------------------------------------------------------------------
module nsl_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [nsl_pkg::DIM_W-1:0]     numer,
  input  logic [nsl_pkg::COORD_W-1:0]   denom,
  output logic [nsl_pkg::SCALE_W-1:0]   quo
);
  import nsl_pkg::*;

  logic [COORD_W-1:0] rem_r;
  logic [COORD_W-1:0] rem_nxt;
  logic [SCALE_W-1:0] sh_r;
  logic [COORD_W:0]   trial;
  logic               fit;

  always_comb begin
    trial = {rem_r, sh_r[SCALE_W-1]};
    fit   = (trial >= {1'b0, denom});
    if (fit) begin
      rem_nxt = COORD_W'(trial - {1'b0, denom});
    end else begin
      rem_nxt = trial[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      sh_r  <= {numer, {(SCALE_W-DIM_W){1'b0}}};
    end else if (step) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[SCALE_W-2:0], fit};
    end
  end

  assign quo = sh_r;

endmodule

// File: design/nsl_geom.sv
// ---------------------------------------------------------------------------
// nsl_geom: configuration registers and grid geometry
// Holds the registers, clamps borders, lays out both axes and runs the six
// scale divisions after reset or any register write.
// ---------------------------------------------------------------------------
module nsl_geom #(
  parameter int MAX_SPRITE_SIZE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output nsl_pkg::geom_t                  geom,
  output logic                            calc_busy
);
  import nsl_pkg::*;

  localparam int SAT_LIM = (MAX_SPRITE_SIZE > ((1 << COORD_W) - 1)) ?
                           ((1 << COORD_W) - 1) : MAX_SPRITE_SIZE;
  localparam logic [COORD_W-1:0] SAT_V = COORD_W'(SAT_LIM);

  logic [COORD_W-1:0]  sprite_w_r, sprite_h_r;
  logic [BORDER_W-1:0] border_l_r, border_r_r, border_t_r, border_b_r;
  logic [DIM_W-1:0]    target_w_r, target_h_r;

  logic [COORD_W-1:0]  sw, sh;
  logic [DIM_W-1:0]    tw, th;
  axis_t               col_d, row_d;
  axis_t               col_r, row_r;
  logic                present_r;

  calc_state_t         state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                div_load, div_step;
  logic [2:0][SCALE_W-1:0] scale_x, scale_y;

  function automatic axis_t axis_calc(input logic [COORD_W-1:0]  size,
                                      input logic [BORDER_W-1:0] b_lo,
                                      input logic [BORDER_W-1:0] b_hi,
                                      input logic [DIM_W-1:0]    tgt);
    logic [COORD_W-1:0] lo, hi, sum;
    logic [DIM_W-1:0]   span, lo_x, hi_x, sum_x;
    axis_t              a;
    if ((COORD_W'(b_lo) + COORD_W'(b_hi)) > size) begin
      lo = {1'b0, size[COORD_W-1:1]};
      hi = size - lo;
    end else begin
      lo = COORD_W'(b_lo);
      hi = COORD_W'(b_hi);
    end
    sum   = lo + hi;
    lo_x  = DIM_W'(lo);
    hi_x  = DIM_W'(hi);
    sum_x = DIM_W'(sum);
    span  = (tgt > sum_x) ? (tgt - sum_x) : '0;
    a.src_pos[0] = '0;
    a.src_pos[1] = lo;
    a.src_pos[2] = size - hi;
    a.src_len[0] = lo;
    a.src_len[1] = size - sum;
    a.src_len[2] = hi;
    a.dst_len[0] = lo_x;
    a.dst_len[1] = span;
    a.dst_len[2] = hi_x;
    a.dst_off[0] = '0;
    a.dst_off[1] = lo_x;
    a.dst_off[2] = lo_x + span;
    for (int g = 0; g < 3; g++) begin
      a.ok[g] = (a.src_len[g] != '0) && (a.dst_len[g] != '0);
    end
    return a;
  endfunction

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_w_r <= '0;
      sprite_h_r <= '0;
      border_l_r <= '0;
      border_r_r <= '0;
      border_t_r <= '0;
      border_b_r <= '0;
      target_w_r <= DIM_W'(1);
      target_h_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPRITE_W: sprite_w_r <= cfg_data[COORD_W-1:0];
        REG_SPRITE_H: sprite_h_r <= cfg_data[COORD_W-1:0];
        REG_BORDER_L: border_l_r <= cfg_data[BORDER_W-1:0];
        REG_BORDER_R: border_r_r <= cfg_data[BORDER_W-1:0];
        REG_BORDER_T: border_t_r <= cfg_data[BORDER_W-1:0];
        REG_BORDER_B: border_b_r <= cfg_data[BORDER_W-1:0];
        REG_TARGET_W: target_w_r <= cfg_data[DIM_W-1:0];
        REG_TARGET_H: target_h_r <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    sw    = (sprite_w_r > SAT_V) ? SAT_V : sprite_w_r;
    sh    = (sprite_h_r > SAT_V) ? SAT_V : sprite_h_r;
    tw    = (target_w_r == '0) ? DIM_W'(1) : target_w_r;
    th    = (target_h_r == '0) ? DIM_W'(1) : target_h_r;
    col_d = axis_calc(sw, border_l_r, border_r_r, tw);
    row_d = axis_calc(sh, border_t_r, border_b_r, th);
  end

  // Latch the layout at the start of a recalculation
  always_ff @(posedge clk) begin
    if (div_load) begin
      col_r     <= col_d;
      row_r     <= row_d;
      present_r <= (sw != '0) && (sh != '0);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    nsl_div u_div_x (
      .clk   (clk),
      .load  (div_load),
      .step  (div_step),
      .numer (col_d.dst_len[g]),
      .denom (col_r.src_len[g]),
      .quo   (scale_x[g])
    );
    nsl_div u_div_y (
      .clk   (clk),
      .load  (div_load),
      .step  (div_step),
      .numer (row_d.dst_len[g]),
      .denom (row_r.src_len[g]),
      .quo   (scale_y[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CALC_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_load  = 1'b0;
    div_step  = 1'b0;
    unique case (state_r)
      CALC_LOAD: begin
        div_load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = CALC_RUN;
      end
      CALC_RUN: begin
        div_step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = CALC_IDLE;
        end
      end
      CALC_IDLE: begin
      end
      default: state_nxt = CALC_LOAD;
    endcase
    if (cfg_we) begin
      state_nxt = CALC_LOAD;
    end
  end

  assign calc_busy     = (state_r != CALC_IDLE);
  assign geom.col      = col_r;
  assign geom.row      = row_r;
  assign geom.scale_x  = scale_x;
  assign geom.scale_y  = scale_y;
  assign geom.present  = present_r;

  a_write_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == CALC_LOAD))
    else $error("register write did not restart the layout calculation");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CALC_RUN && cnt_r == DIV_CNT_W'(DIV_STEPS - 1) && !cfg_we)
      |=> (state_r == CALC_IDLE))
    else $error("layout calculation overran its step count");

endmodule

// File: design/nsl_front.sv
// ---------------------------------------------------------------------------
// nsl_front: request intake
// Accepts a position, works out the span origins and the mask of non-empty
// slices, and queues the request; requests with no slices are dropped.
// ---------------------------------------------------------------------------
module nsl_front (
  input  logic                              start,
  input  logic signed [nsl_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [nsl_pkg::POS_W-1:0]  in_pos_y,
  input  nsl_pkg::geom_t                    geom,
  input  logic                              calc_busy,
  input  logic                              q_full,
  output logic                              busy,
  output logic                              push,
  output nsl_pkg::slice_req_t               req
);
  import nsl_pkg::*;

  logic [DST_W-1:0] px, py;

  always_comb begin
    px = {{(DST_W-POS_W){in_pos_x[POS_W-1]}}, in_pos_x};
    py = {{(DST_W-POS_W){in_pos_y[POS_W-1]}}, in_pos_y};
    for (int g = 0; g < 3; g++) begin
      req.dst_x[g] = px + DST_W'(geom.col.dst_off[g]);
      req.dst_y[g] = py + DST_W'(geom.row.dst_off[g]);
    end
    for (int k = 0; k < SLICES; k++) begin
      req.mask[k] = geom.present
                  & geom.col.ok[slice_col(IDX_W'(k))]
                  & geom.row.ok[slice_row(IDX_W'(k))];
    end
    busy = calc_busy | q_full;
    push = start & ~busy & (|req.mask);
  end

endmodule

// File: design/nsl_queue.sv
// ---------------------------------------------------------------------------
// nsl_queue: request queue between intake and emitter
// Four entries, push and pop in the same cycle allowed.
// ---------------------------------------------------------------------------
module nsl_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nsl_pkg::slice_req_t  push_req,
  input  logic                 pop,
  output nsl_pkg::slice_req_t  head,
  output logic                 empty,
  output logic                 full
);
  import nsl_pkg::*;

  slice_req_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]    wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign head  = mem[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

endmodule

// File: design/nsl_back.sv
// ---------------------------------------------------------------------------
// nsl_back: slice emitter
// Walks the slice mask of the current request, one blit command a cycle,
// and loads the next request in the cycle the last slice goes out.
// ---------------------------------------------------------------------------
module nsl_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nsl_pkg::geom_t                    geom,
  input  logic                              calc_busy,
  input  logic                              q_empty,
  input  nsl_pkg::slice_req_t               head,
  output logic                              pop,
  output logic                              out_strobe,
  output logic [nsl_pkg::IDX_W-1:0]         out_slice_index,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_s,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_t,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_w,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_h,
  output logic signed [nsl_pkg::DST_W-1:0]  out_dst_x,
  output logic signed [nsl_pkg::DST_W-1:0]  out_dst_y,
  output logic [nsl_pkg::DIM_W-1:0]         out_dst_w,
  output logic [nsl_pkg::DIM_W-1:0]         out_dst_h,
  output logic [nsl_pkg::SCALE_W-1:0]       out_scale_x,
  output logic [nsl_pkg::SCALE_W-1:0]       out_scale_y,
  output logic                              out_last
);
  import nsl_pkg::*;

  slice_req_t        cur_r;
  logic [SLICES-1:0] rem_r, rem_nxt;
  logic [SLICES-1:0] low;
  logic [IDX_W-1:0]  k;
  logic [1:0]        row, col;
  logic              done;

  logic                out_strobe_r;
  logic [IDX_W-1:0]    out_slice_index_r;
  logic [COORD_W-1:0]  out_src_s_r, out_src_t_r, out_src_w_r, out_src_h_r;
  logic [DST_W-1:0]    out_dst_x_r, out_dst_y_r;
  logic [DIM_W-1:0]    out_dst_w_r, out_dst_h_r;
  logic [SCALE_W-1:0]  out_scale_x_r, out_scale_y_r;
  logic                out_last_r;

  always_comb begin
    low = rem_r & (~rem_r + 1'b1);
    k   = '0;
    for (int i = 0; i < SLICES; i++) begin
      if (low[i]) begin
        k = IDX_W'(i);
      end
    end
    row     = slice_row(k);
    col     = slice_col(k);
    done    = ((rem_r & ~low) == '0);
    pop     = done & ~q_empty;
    rem_nxt = pop ? head.mask : (rem_r & ~low);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      rem_r        <= rem_nxt;
      out_strobe_r <= |rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    out_slice_index_r <= k;
    out_src_s_r       <= geom.col.src_pos[col];
    out_src_t_r       <= geom.row.src_pos[row];
    out_src_w_r       <= geom.col.src_len[col];
    out_src_h_r       <= geom.row.src_len[row];
    out_dst_x_r       <= cur_r.dst_x[col];
    out_dst_y_r       <= cur_r.dst_y[row];
    out_dst_w_r       <= geom.col.dst_len[col];
    out_dst_h_r       <= geom.row.dst_len[row];
    out_scale_x_r     <= geom.scale_x[col];
    out_scale_y_r     <= geom.scale_y[row];
    out_last_r        <= done;
  end

  assign out_strobe      = out_strobe_r;
  assign out_slice_index = out_slice_index_r;
  assign out_src_s       = out_src_s_r;
  assign out_src_t       = out_src_t_r;
  assign out_src_w       = out_src_w_r;
  assign out_src_h       = out_src_h_r;
  assign out_dst_x       = out_dst_x_r;
  assign out_dst_y       = out_dst_y_r;
  assign out_dst_w       = out_dst_w_r;
  assign out_dst_h       = out_dst_h_r;
  assign out_scale_x     = out_scale_x_r;
  assign out_scale_y     = out_scale_y_r;
  assign out_last        = out_last_r;

  a_geom_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> !calc_busy)
    else $error("slices emitted while the layout was being recalculated");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_last_r) |-> (rem_r != '0))
    else $error("request ended without a last slice");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (rem_r != '0))
    else $error("queued request carried no slice");

endmodule

// File: design/nine_slice_layout_unit.sv
// ---------------------------------------------------------------------------
// nine_slice_layout_unit: nine-slice sprite layout engine
// Turns a destination position into up to nine blit commands, row-major,
// each with source and destination rectangles and 16.16 scale factors.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -------------------------------------------
//  input    start, busy            in_pos_x, in_pos_y
//  result   out_strobe (1 cycle)   slice index, src rect, dst rect, scales, last
//  config   cfg_we                 cfg_index, cfg_data
//
//  A request is taken at an edge with start high and busy low. The emitter
//  issues one command for each non-empty slice, one a cycle; requests whose
//  layout has no slice are dropped at intake. With the emitter idle, a request
//  passes through the queue, the emitter's slice mask register and the output
//  registers before its first command is on the result ports. After reset and
//  after every register write, busy stays high while the six scale factors go
//  through the bit-serial dividers. Results cannot be held off; a four-entry
//  request queue lets intake keep accepting while the emitter works through
//  the current request.
// ---------------------------------------------------------------------------
module nine_slice_layout_unit #(
  parameter int MAX_SPRITE_SIZE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request intake
  input  logic                              start,
  output logic                              busy,
  input  logic signed [nsl_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [nsl_pkg::POS_W-1:0]  in_pos_y,
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [nsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsl_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Blit commands
  output logic                              out_strobe,
  output logic [nsl_pkg::IDX_W-1:0]         out_slice_index,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_s,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_t,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_w,
  output logic [nsl_pkg::COORD_W-1:0]       out_src_h,
  output logic signed [nsl_pkg::DST_W-1:0]  out_dst_x,
  output logic signed [nsl_pkg::DST_W-1:0]  out_dst_y,
  output logic [nsl_pkg::DIM_W-1:0]         out_dst_w,
  output logic [nsl_pkg::DIM_W-1:0]         out_dst_h,
  output logic [nsl_pkg::SCALE_W-1:0]       out_scale_x,
  output logic [nsl_pkg::SCALE_W-1:0]       out_scale_y,
  output logic                              out_last
);
  import nsl_pkg::*;

  geom_t      geom;
  logic       calc_busy;
  logic       q_full, q_empty;
  logic       push, pop;
  slice_req_t req;
  slice_req_t head;

  // Registers, clamped layout and scale dividers
  nsl_geom #(
    .MAX_SPRITE_SIZE (MAX_SPRITE_SIZE)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .calc_busy (calc_busy)
  );

  // Intake: hold off requests while recalculating or the queue is full
  nsl_front u_front (
    .start     (start),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .geom      (geom),
    .calc_busy (calc_busy),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .req       (req)
  );

  nsl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (req),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Emitter: advance one slice a cycle, drop to the next request on the last
  nsl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .geom            (geom),
    .calc_busy       (calc_busy),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_slice_index (out_slice_index),
    .out_src_s       (out_src_s),
    .out_src_t       (out_src_t),
    .out_src_w       (out_src_w),
    .out_src_h       (out_src_h),
    .out_dst_x       (out_dst_x),
    .out_dst_y       (out_dst_y),
    .out_dst_w       (out_dst_w),
    .out_dst_h       (out_dst_h),
    .out_scale_x     (out_scale_x),
    .out_scale_y     (out_scale_y),
    .out_last        (out_last)
  );

endmodule
